FILE: hw/rtl/mfbp_pkg.sv
package mfbp_pkg;

  localparam int CODE_MAX_BITS_DEF = 32;
  localparam int CODE_FIELD_BITS   = 32;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_CODE  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_ONE   = 8'h31;
  localparam logic [7:0] ASCII_EIGHT = 8'h38;

  typedef struct packed {
    logic push;
    logic bit_val;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic [7:0] partial;
    logic [2:0] count;
    logic       byte_done;
    logic [7:0] done_byte;
  } acc_stat_t;

endpackage

FILE: hw/rtl/mfbp_acc.sv
module mfbp_acc (
  input  logic              clk,
  input  logic              rst,
  input  mfbp_pkg::acc_ctl_t  ctl,
  output mfbp_pkg::acc_stat_t stat
);
  import mfbp_pkg::*;

  logic [7:0] partial;
  logic [2:0] count;
  logic [7:0] merged;

  // new bit lands at position 7 - count
  assign merged = partial | ({7'b0, ctl.bit_val} << (3'd7 - count));

  assign stat.partial   = partial;
  assign stat.count     = count;
  assign stat.byte_done = ctl.push && (count == 3'd7);
  assign stat.done_byte = merged;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      partial <= 8'd0;
      count   <= 3'd0;
    end else if (ctl.push) begin
      if (count == 3'd7) begin
        partial <= 8'd0;
      end else begin
        partial <= merged;
      end
      count <= count + 3'd1;
    end
  end

endmodule

FILE: hw/rtl/msb_first_bit_packer.sv
// channel | handshake            | fields
// in      | in_valid / in_stall   | req_type, byte_value, code_bits, code_length
// out     | out_valid / out_stall | out_byte, is_last
//
// A request is taken in idle, then one bit is appended per cycle while the
// output slot is free: a raw byte appends 8 bits, a code code_length bits
// capped at CODE_MAX_BITS and at the 32-bit code field, a flush one or two
// words. All bits pass one at a time through the single bit accumulator.
// rst clears the packer to empty.
// Shifting pauses while a completed word waits in the output register.
module msb_first_bit_packer #(
  parameter int CODE_MAX_BITS = mfbp_pkg::CODE_MAX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  byte_value,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_last
);
  import mfbp_pkg::*;

  localparam int LenCap = (CODE_MAX_BITS < CODE_FIELD_BITS) ? CODE_MAX_BITS : CODE_FIELD_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FLUSH_DATA,
    S_FLUSH_TRAIL
  } state_t;

  state_t      state;
  logic [31:0] src;
  logic [4:0]  idx;
  logic [5:0]  rem;
  logic [5:0]  len_sat;
  logic        slot_free;
  logic        accept;
  logic        load;
  acc_ctl_t    acc_ctl;
  acc_stat_t   acc_stat;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign len_sat   = (code_length > 6'(LenCap)) ? 6'(LenCap) : code_length;
  assign load      = slot_free && (((state == S_SHIFT) && acc_stat.byte_done) ||
                                   (state == S_FLUSH_DATA) || (state == S_FLUSH_TRAIL));

  always_comb begin
    acc_ctl.push    = (state == S_SHIFT) && slot_free;
    acc_ctl.bit_val = src[idx];
    acc_ctl.clear   = (state == S_FLUSH_TRAIL) && slot_free;
  end

  mfbp_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (acc_ctl),
    .stat (acc_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_BYTE: begin
                src   <= {24'b0, byte_value};
                idx   <= 5'd7;
                rem   <= 6'd8;
                state <= S_SHIFT;
              end
              REQ_CODE: begin
                src <= code_bits;
                idx <= 5'(len_sat - 6'd1);
                rem <= len_sat;
                if (len_sat != 6'd0) begin
                  state <= S_SHIFT;
                end
              end
              REQ_FLUSH: begin
                state <= (acc_stat.count != 3'd0) ? S_FLUSH_DATA : S_FLUSH_TRAIL;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (slot_free) begin
            if (acc_stat.byte_done) begin
              out_valid <= 1'b1;
              out_byte  <= acc_stat.done_byte;
              is_last   <= 1'b0;
            end
            idx <= idx - 5'd1;
            rem <= rem - 6'd1;
            if (rem == 6'd1) begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH_DATA: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_byte  <= acc_stat.partial;
            is_last   <= 1'b0;
            state     <= S_FLUSH_TRAIL;
          end
        end
        S_FLUSH_TRAIL: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_byte  <= (acc_stat.count == 3'd0) ? ASCII_EIGHT
                                                  : ASCII_ZERO + {5'b0, acc_stat.count};
            is_last   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_trail_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> (out_byte >= ASCII_ONE) && (out_byte <= ASCII_EIGHT))
    else $error("trailer digit out of range");

  a_trail_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_TRAIL) && slot_free |=> (acc_stat.count == 3'd0) && (state == S_IDLE))
    else $error("packer not cleared after trailer");

  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_FLUSH) && (acc_stat.count == 3'd0) |=> state == S_FLUSH_TRAIL)
    else $error("empty flush emitted a data word");

  a_shift_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> rem != 6'd0)
    else $error("shifting with no bits left");

endmodule
